>>> rtl/mtgt_pkg.sv
// ----------------------------------------------------------------------------
// mtgt_pkg
// Shared types and constants of the multi-touch gesture tracker.
// ----------------------------------------------------------------------------
package mtgt_pkg;

    localparam int MAX_POINTS = 10;
    localparam int SLOT_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] NO_SLOT = 4'hF;

    // event kinds
    localparam logic [2:0] OP_PRESS        = 3'd0;
    localparam logic [2:0] OP_TOUCH_BEGIN  = 3'd1;
    localparam logic [2:0] OP_MOTION       = 3'd2;
    localparam logic [2:0] OP_TOUCH_UPDATE = 3'd3;
    localparam logic [2:0] OP_RELEASE      = 3'd4;
    localparam logic [2:0] OP_TOUCH_END    = 3'd5;
    localparam logic [2:0] OP_TOUCH_CANCEL = 3'd6;
    localparam logic [2:0] OP_CANCEL       = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_REQUIRED_POINTS = 2'd0;
    localparam logic [1:0] REG_DRAG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_TRIGGER_EDGE    = 2'd2;
    localparam logic [1:0] REG_ACTION_ENABLED  = 2'd3;

    localparam logic [1:0] EDGE_NONE   = 2'd0;
    localparam logic [1:0] EDGE_CANCEL = 2'd1;
    localparam logic [1:0] EDGE_BEGIN  = 2'd2;

    typedef struct packed {
        logic [7:0]         device;
        logic [7:0]         sequence_id;
        logic signed [19:0] press_x;
        logic signed [19:0] press_y;
        logic signed [19:0] last_x;
        logic signed [19:0] last_y;
        logic [31:0]        last_time;
        logic signed [20:0] delta_x;
        logic signed [20:0] delta_y;
        logic [31:0]        delta_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/mtgt_ram.sv
// ----------------------------------------------------------------------------
// mtgt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/multi_touch_gesture_tracker_core.sv
// ----------------------------------------------------------------------------
// multi_touch_gesture_tracker_core
// Point table and gesture state machine for pointer and touch events.
// ----------------------------------------------------------------------------
// Usage: events enter on the s_ stream (s_tuser = event kind), one result
// word per event leaves on the m_ stream. Settings are written through
// cfg_we/cfg_addr/cfg_wdata while the block is idle.
// The point table sits in one RAM of MAX_POINTS entries with registered
// read data. Press and cancel events pass ST_PRESS, then ST_FIN loads the
// output register. Motion, update and release events search the table
// slot by slot (read, compare), then update and finish; an event that
// matches no point finishes after the search of all active points.
// A release also closes the gap in the table, moving each later entry
// down by one slot (read, write).
// One event is in work at a time; s_tready is high only while idle.
// The result waits in an output register; the next event may be accepted
// while it waits, and its own result stalls until m_tready takes the first.
// Reset (aresetn low, synchronous) empties the table, clears the gesture
// flag and loads the default settings; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_touch_gesture_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // device_id, sequence_id, pos_x, pos_y, event_time, button_down,
    // begin_accept, progress_accept
    input  logic [95:0] s_tdata,
    // op
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // signal_begin, signal_progress, signal_end, signal_cancel, point_slot,
    // active_points, gesture_active, delta_x, delta_y, delta_time
    output logic [87:0] m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRESS = 3'd1;
    localparam logic [2:0] ST_SRD   = 3'd2;
    localparam logic [2:0] ST_SCMP  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_SHRD  = 3'd5;
    localparam logic [2:0] ST_SHWR  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    localparam int SW = mtgt_pkg::SLOT_W;
    localparam int CW = mtgt_pkg::CNT_W;

    logic [2:0]  state_reg;
    logic [3:0]  req_reg;
    logic [9:0]  thr_reg;
    logic [1:0]  edge_reg;
    logic        enable_reg;

    logic [2:0]         op_reg;
    logic [7:0]         dev_reg;
    logic [7:0]         seq_reg;
    logic signed [19:0] x_reg;
    logic signed [19:0] y_reg;
    logic [31:0]        t_reg;
    logic               btn_reg;
    logic               bacc_reg;
    logic               pacc_reg;

    logic [CW-1:0] count_reg;
    logic          flag_reg;
    logic [CW-1:0] idx_reg;
    mtgt_pkg::entry_t ent_reg;

    logic               res_begin_reg;
    logic               res_prog_reg;
    logic               res_end_reg;
    logic               res_cancel_reg;
    logic [3:0]         res_slot_reg;
    logic signed [20:0] res_dx_reg;
    logic signed [20:0] res_dy_reg;
    logic [31:0]        res_dt_reg;

    logic        m_valid_reg;
    logic [87:0] m_data_reg;

    logic                   ram_we;
    logic [SW-1:0]          ram_waddr;
    mtgt_pkg::entry_t       ram_wdata;
    logic                   ram_re;
    logic [SW-1:0]          ram_raddr;
    logic [mtgt_pkg::ENTRY_W-1:0] ram_rdata_bits;
    mtgt_pkg::entry_t       ram_rdata;

    assign ram_rdata = mtgt_pkg::entry_t'(ram_rdata_bits);

    mtgt_ram #(
        .WIDTH(mtgt_pkg::ENTRY_W),
        .DEPTH(mtgt_pkg::MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

    // ---- event decode ----
    logic is_press;
    logic is_motion;
    logic [7:0] key;
    logic press_store;
    logic press_begin;
    logic [CW-1:0] press_count;
    mtgt_pkg::entry_t press_ent;

    assign is_press  = (op_reg == mtgt_pkg::OP_PRESS) || (op_reg == mtgt_pkg::OP_TOUCH_BEGIN);
    assign is_motion = (op_reg == mtgt_pkg::OP_MOTION) ||
                       (op_reg == mtgt_pkg::OP_TOUCH_UPDATE);
    assign key = ((op_reg == mtgt_pkg::OP_MOTION) || (op_reg == mtgt_pkg::OP_RELEASE)) ?
                 8'd0 : seq_reg;

    assign press_store = enable_reg && (count_reg < CW'(mtgt_pkg::MAX_POINTS));
    assign press_count = press_store ? count_reg + CW'(1) : count_reg;
    assign press_begin = enable_reg && (5'(press_count) >= 5'(req_reg)) &&
                         (edge_reg != mtgt_pkg::EDGE_BEGIN);

    always_comb begin
        press_ent             = '0;
        press_ent.device      = dev_reg;
        press_ent.sequence_id = (op_reg == mtgt_pkg::OP_PRESS) ? 8'd0 : seq_reg;
        press_ent.press_x     = x_reg;
        press_ent.press_y     = y_reg;
        press_ent.last_x      = x_reg;
        press_ent.last_y      = y_reg;
        press_ent.last_time   = t_reg;
    end

    // ---- update arithmetic on the matched entry ----
    logic signed [20:0] mdx, mdy, pdx, pdy;
    logic [20:0]        adx, ady;
    logic [13:0]        thr16;
    logic [32:0]        tdiff;
    logic [31:0]        mdt;
    logic               inside_thr, past_thr;
    logic signed [34:0] rsum;
    logic [31:0]        rdt;
    mtgt_pkg::entry_t   upd_ent;

    always_comb begin
        mdx   = 21'(x_reg) - 21'(ent_reg.last_x);
        mdy   = 21'(y_reg) - 21'(ent_reg.last_y);
        pdx   = 21'(ent_reg.press_x) - 21'(x_reg);
        pdy   = 21'(ent_reg.press_y) - 21'(y_reg);
        adx   = pdx[20] ? 21'(-pdx) : 21'(pdx);
        ady   = pdy[20] ? 21'(-pdy) : 21'(pdy);
        thr16 = {thr_reg, 4'b0000};
        inside_thr = (ady < 21'(thr16)) && (adx < 21'(thr16));
        past_thr   = (ady > 21'(thr16)) || (adx > 21'(thr16));
        tdiff = {1'b0, t_reg} - {1'b0, ent_reg.last_time};
        mdt   = tdiff[32] ? 32'd0 : tdiff[31:0];
        // release adds its interval to the stored delta time
        rsum  = 35'({3'b000, ent_reg.delta_time}) + 35'(signed'(tdiff));
        if (rsum[34]) begin
            rdt = 32'd0;
        end else if (rsum[33:32] != 2'b00) begin
            rdt = 32'hFFFF_FFFF;
        end else begin
            rdt = rsum[31:0];
        end
        upd_ent            = ent_reg;
        upd_ent.delta_x    = mdx;
        upd_ent.delta_y    = mdy;
        upd_ent.last_x     = x_reg;
        upd_ent.last_y     = y_reg;
        upd_ent.delta_time = mdt;
        upd_ent.last_time  = t_reg;
    end

    // motion decision
    logic m_write, m_begin, m_prog, m_cancel, m_flag;
    logic go;

    always_comb begin
        m_write  = 1'b0;
        m_begin  = 1'b0;
        m_prog   = 1'b0;
        m_cancel = 1'b0;
        m_flag   = flag_reg;
        go       = 1'b1;
        if ((op_reg == mtgt_pkg::OP_MOTION) && !btn_reg) begin
            m_cancel = 1'b1;
            m_flag   = 1'b0;
            go       = 1'b0;
        end
        if (go && !flag_reg) begin
            if ((5'(count_reg) < 5'(req_reg)) ||
                ((edge_reg == mtgt_pkg::EDGE_BEGIN) && inside_thr)) begin
                m_write = 1'b1;
                go      = 1'b0;
            end else if (!bacc_reg) begin
                m_cancel = 1'b1;
                m_flag   = 1'b0;
                go       = 1'b0;
            end else begin
                m_begin = 1'b1;
                m_flag  = 1'b1;
            end
        end
        if (go) begin
            m_write = 1'b1;
            m_prog  = 1'b1;
            if (!pacc_reg || ((edge_reg == mtgt_pkg::EDGE_CANCEL) && past_thr)) begin
                m_cancel = 1'b1;
                m_flag   = 1'b0;
            end
        end
    end

    // ---- RAM control ----
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[SW-1:0];
        ram_wdata = upd_ent;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[SW-1:0];
        case (state_reg)
            ST_PRESS: begin
                ram_we    = is_press && press_store;
                ram_waddr = count_reg[SW-1:0];
                ram_wdata = press_ent;
            end
            ST_SRD: begin
                ram_re = idx_reg < count_reg;
            end
            ST_UPD: begin
                ram_we = is_motion && m_write;
            end
            ST_SHRD: begin
                ram_re    = 1'b1;
                ram_raddr = SW'(idx_reg + CW'(1));
            end
            ST_SHWR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default: begin
            end
        endcase
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            req_reg     <= 4'd1;
            thr_reg     <= 10'd8;
            edge_reg    <= mtgt_pkg::EDGE_BEGIN;
            enable_reg  <= 1'b1;
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    mtgt_pkg::REG_REQUIRED_POINTS: req_reg    <= cfg_wdata[3:0];
                    mtgt_pkg::REG_DRAG_THRESHOLD:  thr_reg    <= cfg_wdata;
                    mtgt_pkg::REG_TRIGGER_EDGE:    edge_reg   <= cfg_wdata[1:0];
                    mtgt_pkg::REG_ACTION_ENABLED:  enable_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            // in ST_FIN the output register is reloaded below
            if (m_valid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg   <= s_tuser;
                        dev_reg  <= s_tdata[7:0];
                        seq_reg  <= s_tdata[15:8];
                        x_reg    <= s_tdata[35:16];
                        y_reg    <= s_tdata[55:36];
                        t_reg    <= s_tdata[87:56];
                        btn_reg  <= s_tdata[88];
                        bacc_reg <= s_tdata[89];
                        pacc_reg <= s_tdata[90];
                        idx_reg  <= '0;
                        res_begin_reg  <= 1'b0;
                        res_prog_reg   <= 1'b0;
                        res_end_reg    <= 1'b0;
                        res_cancel_reg <= 1'b0;
                        res_slot_reg   <= mtgt_pkg::NO_SLOT;
                        res_dx_reg     <= '0;
                        res_dy_reg     <= '0;
                        res_dt_reg     <= '0;
                        state_reg      <= ST_PRESS;
                    end
                end
                ST_PRESS: begin
                    if (op_reg == mtgt_pkg::OP_CANCEL) begin
                        res_cancel_reg <= 1'b1;
                        count_reg      <= '0;
                        flag_reg       <= 1'b0;
                        state_reg      <= ST_FIN;
                    end else if (is_press) begin
                        if (press_store) begin
                            res_slot_reg <= 4'(count_reg);
                        end
                        // a rejected begin clears the table
                        count_reg <= (press_begin && !bacc_reg) ? '0 : press_count;
                        if (press_begin) begin
                            if (bacc_reg) begin
                                res_begin_reg <= 1'b1;
                                flag_reg      <= 1'b1;
                            end else begin
                                res_cancel_reg <= 1'b1;
                                flag_reg       <= 1'b0;
                            end
                        end
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_SRD;
                    end
                end
                ST_SRD: begin
                    state_reg <= (idx_reg < count_reg) ? ST_SCMP : ST_FIN;
                end
                ST_SCMP: begin
                    ent_reg <= ram_rdata;
                    if ((ram_rdata.device == dev_reg) && (ram_rdata.sequence_id == key)) begin
                        state_reg <= ST_UPD;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_SRD;
                    end
                end
                ST_UPD: begin
                    res_slot_reg <= 4'(idx_reg);
                    if (is_motion) begin
                        res_dx_reg     <= m_write ? mdx : ent_reg.delta_x;
                        res_dy_reg     <= m_write ? mdy : ent_reg.delta_y;
                        res_dt_reg     <= m_write ? mdt : ent_reg.delta_time;
                        res_begin_reg  <= m_begin;
                        res_prog_reg   <= m_prog;
                        res_cancel_reg <= m_cancel;
                        flag_reg       <= m_flag;
                        if (m_cancel) begin
                            count_reg <= '0;
                        end
                        state_reg <= ST_FIN;
                    end else begin
                        res_dx_reg <= ent_reg.delta_x;
                        res_dy_reg <= ent_reg.delta_y;
                        res_dt_reg <= rdt;
                        if ((op_reg == mtgt_pkg::OP_TOUCH_CANCEL) && flag_reg) begin
                            res_cancel_reg <= 1'b1;
                            flag_reg       <= 1'b0;
                            count_reg      <= '0;
                            state_reg      <= ST_FIN;
                        end else begin
                            if ((op_reg != mtgt_pkg::OP_TOUCH_CANCEL) && flag_reg &&
                                ((5'(count_reg) - 5'd1) < 5'(req_reg))) begin
                                res_end_reg <= 1'b1;
                                flag_reg    <= 1'b0;
                            end
                            state_reg <= ST_SHRD;
                        end
                    end
                end
                ST_SHRD: begin
                    // compact: move entry idx+1 down to idx
                    if ((idx_reg + CW'(1)) < count_reg) begin
                        state_reg <= ST_SHWR;
                    end else begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= ST_FIN;
                    end
                end
                ST_SHWR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_SHRD;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, res_dt_reg, res_dy_reg, res_dx_reg, flag_reg,
                                        4'(count_reg), res_slot_reg, res_cancel_reg,
                                        res_end_reg, res_prog_reg, res_begin_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/mtgt_checker.sv
// ----------------------------------------------------------------------------
// mtgt_checker
// Port-level assertions for the gesture tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mtgt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:8] <= 4'(mtgt_pkg::MAX_POINTS))
        else $error("active points above table size");

    // a begin that is not cancelled in the same word leaves the gesture active
    a_begin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] && !m_tdata[3] |-> m_tdata[12])
        else $error("begin without active gesture");

    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[12] && m_tdata[11:8] == 4'd0)
        else $error("cancel left points or gesture");

    // no matched point means no deltas
    a_noslot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:4] == mtgt_pkg::NO_SLOT |-> m_tdata[86:13] == '0)
        else $error("deltas without a matched point");

endmodule

bind multi_touch_gesture_tracker_core mtgt_checker u_mtgt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb_multi_touch_gesture_tracker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_touch_gesture_tracker_core
// Self-checking bench for the gesture tracker: a table of directed events,
// then random gesture sequences, each result word checked field by field
// against a behavioral model of the point table and gesture flag.
// ----------------------------------------------------------------------------
module tb_multi_touch_gesture_tracker_core;

    typedef struct packed {
        logic               progress_accept;
        logic               begin_accept;
        logic               button_down;
        logic [31:0]        event_time;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_x;
        logic [7:0]         sequence_id;
        logic [7:0]         device_id;
    } event_t;

    typedef struct packed {
        logic [31:0]        delta_time;
        logic signed [20:0] delta_y;
        logic signed [20:0] delta_x;
        logic               gesture_active;
        logic [3:0]         active_points;
        logic [3:0]         point_slot;
        logic               signal_cancel;
        logic               signal_end;
        logic               signal_progress;
        logic               signal_begin;
    } verdict_t;

    typedef struct {
        logic [2:0] op;
        event_t     ev;
        logic       has_exp;
        verdict_t   exp_v;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    always #5 aclk = ~aclk;

    multi_touch_gesture_tracker_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // model state
    logic [7:0]         pt_dev  [mtgt_pkg::MAX_POINTS];
    logic [7:0]         pt_seq  [mtgt_pkg::MAX_POINTS];
    logic signed [19:0] pt_px   [mtgt_pkg::MAX_POINTS];
    logic signed [19:0] pt_py   [mtgt_pkg::MAX_POINTS];
    logic signed [19:0] pt_lx   [mtgt_pkg::MAX_POINTS];
    logic signed [19:0] pt_ly   [mtgt_pkg::MAX_POINTS];
    logic [31:0]        pt_lt   [mtgt_pkg::MAX_POINTS];
    logic signed [20:0] pt_dx   [mtgt_pkg::MAX_POINTS];
    logic signed [20:0] pt_dy   [mtgt_pkg::MAX_POINTS];
    logic [31:0]        pt_dt   [mtgt_pkg::MAX_POINTS];
    int                 n_points = 0;
    logic               gesture_on = 1'b0;
    int                 need_points = 1;
    int                 threshold = 8;
    logic [1:0]         edge_mode = mtgt_pkg::EDGE_BEGIN;
    logic               enabled = 1'b1;

    verdict_t expected_q[$];
    verdict_t rv;
    int  errors = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_long = 1'b0;
    bit  burst_stall = 1'b0;
    bit  done = 1'b0;

    function automatic logic [31:0] clamp_time(longint v);
        if (v < 0) return 32'd0;
        if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void take_point(int i);
        rv.point_slot = i[3:0];
        rv.delta_x    = pt_dx[i];
        rv.delta_y    = pt_dy[i];
        rv.delta_time = pt_dt[i];
    endfunction

    function automatic void drop_all();
        gesture_on = 1'b0;
        rv.signal_cancel = 1'b1;
        n_points = 0;
    endfunction

    function automatic bit start_gesture(logic acc);
        gesture_on = 1'b1;
        if (!acc) begin
            drop_all();
            return 1'b0;
        end
        rv.signal_begin = 1'b1;
        return 1'b1;
    endfunction

    function automatic void move_point(int i, event_t e);
        pt_dx[i] = 21'(longint'(e.pos_x) - longint'(pt_lx[i]));
        pt_dy[i] = 21'(longint'(e.pos_y) - longint'(pt_ly[i]));
        pt_lx[i] = e.pos_x;
        pt_ly[i] = e.pos_y;
        pt_dt[i] = clamp_time(longint'(e.event_time) - longint'(pt_lt[i]));
        pt_lt[i] = e.event_time;
        take_point(i);
    endfunction

    function automatic verdict_t track_event(logic [2:0] op, event_t e);
        longint thr;
        int     pos;
        bit     go;
        logic [7:0] key;
        thr = longint'(threshold) * 16;
        rv = '0;
        rv.point_slot = mtgt_pkg::NO_SLOT;
        if (op == mtgt_pkg::OP_PRESS || op == mtgt_pkg::OP_TOUCH_BEGIN) begin
            if (enabled) begin
                if (n_points < mtgt_pkg::MAX_POINTS) begin
                    pt_dev[n_points] = e.device_id;
                    pt_seq[n_points] = (op == mtgt_pkg::OP_PRESS) ? 8'd0 : e.sequence_id;
                    pt_px[n_points] = e.pos_x; pt_py[n_points] = e.pos_y;
                    pt_lx[n_points] = e.pos_x; pt_ly[n_points] = e.pos_y;
                    pt_lt[n_points] = e.event_time;
                    pt_dx[n_points] = '0; pt_dy[n_points] = '0; pt_dt[n_points] = '0;
                    n_points++;
                    take_point(n_points - 1);
                end
                if (n_points >= need_points && edge_mode != mtgt_pkg::EDGE_BEGIN)
                    void'(start_gesture(e.begin_accept));
            end
        end else if (op == mtgt_pkg::OP_CANCEL) begin
            drop_all();
        end else begin
            key = (op == mtgt_pkg::OP_MOTION || op == mtgt_pkg::OP_RELEASE) ?
                  8'd0 : e.sequence_id;
            pos = -1;
            for (int i = 0; i < n_points; i++)
                if (pos < 0 && pt_dev[i] == e.device_id && pt_seq[i] == key) pos = i;
            if (pos >= 0) begin
                take_point(pos);
                if (op == mtgt_pkg::OP_MOTION || op == mtgt_pkg::OP_TOUCH_UPDATE) begin
                    go = 1'b1;
                    if (op == mtgt_pkg::OP_MOTION && !e.button_down) begin
                        drop_all();
                        go = 1'b0;
                    end
                    if (go && !gesture_on) begin
                        if (n_points < need_points || (edge_mode == mtgt_pkg::EDGE_BEGIN &&
                            mag(longint'(pt_py[pos]) - e.pos_y) < thr &&
                            mag(longint'(pt_px[pos]) - e.pos_x) < thr)) begin
                            move_point(pos, e);
                            go = 1'b0;
                        end else if (!start_gesture(e.begin_accept)) begin
                            go = 1'b0;
                        end
                    end
                    if (go) begin
                        move_point(pos, e);
                        rv.signal_progress = 1'b1;
                        if (!e.progress_accept)
                            drop_all();
                        else if (edge_mode == mtgt_pkg::EDGE_CANCEL &&
                                 (mag(longint'(pt_py[pos]) - e.pos_y) > thr ||
                                  mag(longint'(pt_px[pos]) - e.pos_x) > thr))
                            drop_all();
                    end
                end else begin
                    pt_dt[pos] = clamp_time(longint'(pt_dt[pos]) +
                                 (longint'(e.event_time) - longint'(pt_lt[pos])));
                    take_point(pos);
                    if (op == mtgt_pkg::OP_TOUCH_CANCEL) begin
                        if (gesture_on) drop_all();
                    end else if (gesture_on && n_points - 1 < need_points) begin
                        gesture_on = 1'b0;
                        rv.signal_end = 1'b1;
                    end
                    // compaction; a cleared table makes this a no-op
                    if (pos < n_points) begin
                        for (int j = pos; j + 1 < n_points; j++) begin
                            pt_dev[j] = pt_dev[j+1]; pt_seq[j] = pt_seq[j+1];
                            pt_px[j] = pt_px[j+1]; pt_py[j] = pt_py[j+1];
                            pt_lx[j] = pt_lx[j+1]; pt_ly[j] = pt_ly[j+1];
                            pt_lt[j] = pt_lt[j+1]; pt_dx[j] = pt_dx[j+1];
                            pt_dy[j] = pt_dy[j+1]; pt_dt[j] = pt_dt[j+1];
                        end
                        n_points--;
                    end
                end
            end
        end
        rv.active_points  = n_points[3:0];
        rv.gesture_active = gesture_on;
        return rv;
    endfunction

    task automatic set_reg(logic [1:0] idx, int val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val[9:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            mtgt_pkg::REG_REQUIRED_POINTS: need_points = val & 15;
            mtgt_pkg::REG_DRAG_THRESHOLD:  threshold = val & 1023;
            mtgt_pkg::REG_TRIGGER_EDGE:    edge_mode = val[1:0];
            default:                       enabled = val[0];
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        // a release may still be compacting the table
        repeat (40) @(posedge aclk);
    endtask

    // the word stays offered after acceptance until the next call or settle
    task automatic send_event(logic [2:0] op, event_t e, bit typed, verdict_t tv);
        verdict_t p;
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b00000, e};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = track_event(op, e);
        if (typed && p !== tv) begin
            $display("%0t: table row disagrees with model, expected %h actual %h",
                     $time, tv, p);
            errors++;
        end
        expected_q.push_back(p);
    endtask

    function automatic event_t rand_event(int ndev, bit wide);
        event_t e;
        e.device_id   = wide ? 8'($urandom) : 8'($urandom_range(0, ndev));
        e.sequence_id = wide ? 8'($urandom) : 8'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            e.pos_x = 20'($urandom); e.pos_y = 20'($urandom);
        end else begin
            e.pos_x = 20'($urandom_range(0, 600)) - 20'sd300;
            e.pos_y = 20'($urandom_range(0, 600)) - 20'sd300;
        end
        e.event_time      = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 5000);
        e.button_down     = $urandom_range(0, 9) != 0;
        e.begin_accept    = $urandom_range(0, 7) != 0;
        e.progress_accept = $urandom_range(0, 9) != 0;
        return e;
    endfunction

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                verdict_t got, want;
                got = verdict_t'(m_tdata[86:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.signal_begin !== want.signal_begin ||
                        got.signal_progress !== want.signal_progress ||
                        got.signal_end !== want.signal_end ||
                        got.signal_cancel !== want.signal_cancel ||
                        got.point_slot !== want.point_slot ||
                        got.active_points !== want.active_points ||
                        got.gesture_active !== want.gesture_active ||
                        got.delta_x !== want.delta_x || got.delta_y !== want.delta_y ||
                        got.delta_time !== want.delta_time) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (hold_long || burst_stall)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    task automatic force_stall(int n);
        burst_stall = 1'b1;
        repeat (n) @(posedge aclk);
        burst_stall = 1'b0;
    endtask

    // random receiver stall bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!quiet && !hold_long && $urandom_range(0, 20) == 0) begin
                n = $urandom_range(1, 11);
                force_stall(n);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_long || burst_stall)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !done) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t r;
        event_t   e;
        verdict_t v;
        int       nseq, ndev;
        logic [2:0] op;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: default settings, need 1 point, begin after threshold
        e = '0; e.device_id = 8'h01; e.button_down = 1'b1;
        e.begin_accept = 1'b1; e.progress_accept = 1'b1;
        v = '0; v.point_slot = mtgt_pkg::NO_SLOT;
        // motion with empty table: no match
        r.op = mtgt_pkg::OP_MOTION; r.ev = e; r.has_exp = 1'b1; r.exp_v = v;
        rows.push_back(r);
        // press at most negative corner
        e.pos_x = 20'sh80000; e.pos_y = 20'sh80000; e.event_time = 32'd0;
        v = '0; v.point_slot = 4'd0; v.active_points = 4'd1;
        r.op = mtgt_pkg::OP_PRESS; r.ev = e; r.exp_v = v; rows.push_back(r);
        // motion to most positive: passes threshold, begins, progresses
        e.pos_x = 20'sh7FFFF; e.pos_y = 20'sh7FFFF; e.event_time = 32'hFFFF_FFFF;
        r.op = mtgt_pkg::OP_MOTION; r.ev = e; r.has_exp = 1'b0; rows.push_back(r);
        // touch on another device, full sequence id
        e.device_id = 8'hFF; e.sequence_id = 8'hFF; e.event_time = 32'd5;
        r.op = mtgt_pkg::OP_TOUCH_BEGIN; r.ev = e; rows.push_back(r);
        r.op = mtgt_pkg::OP_TOUCH_UPDATE; rows.push_back(r);
        r.op = mtgt_pkg::OP_TOUCH_END; rows.push_back(r);
        e.device_id = 8'h01; e.sequence_id = 8'h00; e.event_time = 32'd0;
        r.op = mtgt_pkg::OP_RELEASE; r.ev = e; rows.push_back(r);
        // cancel with nothing active still signals cancel
        v = '0; v.point_slot = mtgt_pkg::NO_SLOT; v.signal_cancel = 1'b1;
        r.op = mtgt_pkg::OP_CANCEL; r.ev = e; r.has_exp = 1'b1; r.exp_v = v;
        rows.push_back(r);
        // touch cancel and begin rejection and progress rejection and button up
        r.has_exp = 1'b0;
        e.device_id = 8'h22; e.sequence_id = 8'h07;
        r.op = mtgt_pkg::OP_TOUCH_BEGIN; r.ev = e; rows.push_back(r);
        e.pos_x = 20'sd4000; e.begin_accept = 1'b0;
        r.op = mtgt_pkg::OP_TOUCH_UPDATE; r.ev = e; rows.push_back(r);
        e.begin_accept = 1'b1; e.pos_x = 20'sd0;
        r.op = mtgt_pkg::OP_TOUCH_BEGIN; r.ev = e; rows.push_back(r);
        e.pos_x = 20'sd4000; e.progress_accept = 1'b0;
        r.op = mtgt_pkg::OP_TOUCH_UPDATE; r.ev = e; rows.push_back(r);
        e.progress_accept = 1'b1; e.pos_x = 20'sd0;
        r.op = mtgt_pkg::OP_PRESS; r.ev = e; rows.push_back(r);
        e.button_down = 1'b0;
        r.op = mtgt_pkg::OP_MOTION; r.ev = e; rows.push_back(r);
        e.button_down = 1'b1;
        r.op = mtgt_pkg::OP_TOUCH_BEGIN; r.ev = e; rows.push_back(r);
        e.event_time = 32'd100;
        r.op = mtgt_pkg::OP_TOUCH_UPDATE; r.ev = e; rows.push_back(r);
        e.pos_x = 20'sd9000;
        r.op = mtgt_pkg::OP_TOUCH_UPDATE; r.ev = e; rows.push_back(r);
        r.op = mtgt_pkg::OP_TOUCH_CANCEL; r.ev = e; rows.push_back(r);
        // full table: eleven presses on distinct devices
        for (int i = 0; i < 11; i++) begin
            e.device_id = 8'(8'h40 + i);
            r.op = mtgt_pkg::OP_PRESS; r.ev = e; rows.push_back(r);
        end
        foreach (rows[i]) send_event(rows[i].op, rows[i].ev, rows[i].has_exp, rows[i].exp_v);
        settle();

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            set_reg(mtgt_pkg::REG_REQUIRED_POINTS, ph == 0 ? 0 : ph == 1 ? 15 : ph == 2 ? 10 :
                    $urandom_range(1, 4));
            set_reg(mtgt_pkg::REG_DRAG_THRESHOLD, ph == 3 ? 1023 : ph == 4 ? 0 :
                    $urandom_range(0, 20));
            set_reg(mtgt_pkg::REG_TRIGGER_EDGE, ph % 4);
            set_reg(mtgt_pkg::REG_ACTION_ENABLED, ph == 5 ? 0 : 1);
            if (ph == 7) quiet = 1'b1;
            nseq = 0;
            while (nseq < 160) begin
                ndev = $urandom_range(1, 4);
                if ($urandom_range(0, 9) == 0) begin
                    // noise with wide ids
                    op = 3'($urandom);
                    send_event(op, rand_event(ndev, 1'b1), 1'b0, '0);
                    nseq++;
                end else begin
                    // press or begin a few points, move them, then lift
                    int k;
                    bit touch;
                    event_t pts[4];
                    k = $urandom_range(1, 4);
                    touch = $urandom_range(0, 1);
                    for (int p = 0; p < k; p++) begin
                        pts[p] = rand_event(3, 1'b0);
                        pts[p].device_id = 8'(p);
                        pts[p].sequence_id = touch ? 8'(p + 1) : 8'd0;
                        send_event(touch ? mtgt_pkg::OP_TOUCH_BEGIN : mtgt_pkg::OP_PRESS,
                                   pts[p], 1'b0, '0);
                        nseq++;
                    end
                    for (int m = 0; m < $urandom_range(1, 4); m++) begin
                        int p;
                        p = $urandom_range(0, k - 1);
                        e = rand_event(3, 1'b0);
                        e.device_id = pts[p].device_id;
                        e.sequence_id = pts[p].sequence_id;
                        send_event(touch ? mtgt_pkg::OP_TOUCH_UPDATE : mtgt_pkg::OP_MOTION,
                                   e, 1'b0, '0);
                        nseq++;
                    end
                    for (int p = 0; p < k; p++) begin
                        e = rand_event(3, 1'b0);
                        e.device_id = pts[p].device_id;
                        e.sequence_id = pts[p].sequence_id;
                        op = touch ? ($urandom_range(0, 5) == 0 ? mtgt_pkg::OP_TOUCH_CANCEL
                                      : mtgt_pkg::OP_TOUCH_END) : mtgt_pkg::OP_RELEASE;
                        send_event(op, e, 1'b0, '0);
                        nseq++;
                    end
                end
                if (ph == 2 && nseq > 60 && nseq < 70) begin
                    // long receiver stall while the sender keeps offering words
                    fork
                        begin
                            hold_long = 1'b1;
                            repeat (300) @(posedge aclk);
                            hold_long = 1'b0;
                        end
                        begin
                            for (int q = 0; q < 5; q++)
                                send_event(mtgt_pkg::OP_PRESS, rand_event(3, 1'b0), 1'b0, '0);
                        end
                    join
                    nseq += 70;
                end
            end
            settle();
        end

        done = 1'b1;
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
